// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; include guard keeps a second include harmless
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion sampled on clk, off while reset is asserted
`define B64D_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion that is also checked while reset is asserted
`define B64D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/b64d_pkg.sv -----
// package for the unpadded base64 decoder: payload types, queue depth, alphabet lookup
// no dependencies
`timescale 1ns / 1ps

package b64d_pkg;

  // default depth of the queue between classifier and decoder core
  localparam int unsigned QueueDepthDefault = 2;

  // character codes at the edges of the alphabet ranges
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;
  localparam logic [7:0] CharDigit0 = 8'h30;
  localparam logic [7:0] CharDigit9 = 8'h39;
  localparam logic [7:0] CharPlus   = 8'h2B;
  localparam logic [7:0] CharSlash  = 8'h2F;

  // sextet bases of the ranges
  localparam logic [5:0] SextetLowerBase = 6'd26;
  localparam logic [5:0] SextetDigitBase = 6'd52;
  localparam logic [5:0] SextetPlus      = 6'd62;
  localparam logic [5:0] SextetSlash     = 6'd63;

  // quartet positions
  localparam logic [1:0] PosFirst  = 2'd0;
  localparam logic [1:0] PosSecond = 2'd1;
  localparam logic [1:0] PosThird  = 2'd2;
  localparam logic [1:0] PosFourth = 2'd3;

  // input transaction
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_t;

  // output transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_output;
    logic       error;
  } out_t;

  // classified character as it travels through the queue
  typedef struct packed {
    logic [5:0] sextet;
    logic       bad;
    logic       last;
  } cls_t;

  // alphabet lookup; bad characters map to sextet zero
  function automatic cls_t classify(input in_t item);
    cls_t r;
    r.sextet = '0;
    r.bad    = 1'b0;
    r.last   = item.end_of_input;
    if (item.char_byte inside {[CharUpperA:CharUpperZ]}) begin
      r.sextet = 6'(item.char_byte - CharUpperA);
    end else if (item.char_byte inside {[CharLowerA:CharLowerZ]}) begin
      r.sextet = 6'(item.char_byte - CharLowerA) + SextetLowerBase;
    end else if (item.char_byte inside {[CharDigit0:CharDigit9]}) begin
      r.sextet = 6'(item.char_byte - CharDigit0) + SextetDigitBase;
    end else if (item.char_byte == CharPlus) begin
      r.sextet = SextetPlus;
    end else if (item.char_byte == CharSlash) begin
      r.sextet = SextetSlash;
    end else begin
      r.bad = 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/b64d_front.sv -----
// front end: accepts characters and classifies them into sextets
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_front (
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  b64d_pkg::in_t   in_data_i,
  output logic            push_o,
  output b64d_pkg::cls_t  push_data_o,
  input  logic            full_i
);

  // accept whenever the queue has room
  assign in_ready_o  = !full_i;
  assign push_o      = in_valid_i && !full_i;

  // alphabet lookup
  assign push_data_o = b64d_pkg::classify(in_data_i);

endmodule

// ----- rtl/b64d_queue.sv -----
// short queue of classified characters between front end and decoder core
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_queue #(
  parameter int unsigned Depth = b64d_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64d_pkg::cls_t  push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output b64d_pkg::cls_t  pop_data_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

  b64d_pkg::cls_t  slot_q [Depth];
  logic [IdxW-1:0] wr_ptr_q, wr_ptr_d;
  logic [IdxW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign full_o     = (count_q == DepthCnt);
  assign valid_o    = (count_q != '0);
  assign pop_data_o = slot_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/b64d_back.sv -----
// decoder core: quartet state, byte assembly, sticky error and output register
// depends on b64d_pkg
`timescale 1ns / 1ps

module b64d_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  b64d_pkg::cls_t  data_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output b64d_pkg::out_t  out_data_o
);

  logic [1:0]     pos_q, pos_d;
  logic [5:0]     left_q, left_d;
  logic           err_q, err_d;
  logic           out_valid_q, out_valid_d;
  b64d_pkg::out_t out_q, out_d;

  logic [5:0]     sextet;
  logic           err_now;
  logic           err_out;
  logic           completes;
  logic           emit;
  logic           good;
  logic [7:0]     byte_val;
  logic [5:0]     left_next;

  // take a queued character when the output register is free or draining
  assign pop_o = valid_i && (!out_valid_q || out_ready_i);

  // byte assembly for the current quartet position
  always_comb begin
    sextet    = data_i.bad ? 6'd0 : data_i.sextet;
    byte_val  = '0;
    left_next = '0;
    case (pos_q)
      b64d_pkg::PosFirst: begin
        left_next = sextet;
      end
      b64d_pkg::PosSecond: begin
        byte_val  = {left_q, sextet[5:4]};
        left_next = {2'b00, sextet[3:0]};
      end
      b64d_pkg::PosThird: begin
        byte_val  = {left_q[3:0], sextet[5:2]};
        left_next = {4'b0000, sextet[1:0]};
      end
      b64d_pkg::PosFourth: begin
        byte_val  = {left_q[1:0], sextet};
        left_next = '0;
      end
      default: begin
        byte_val  = '0;
        left_next = '0;
      end
    endcase
    err_now   = err_q || data_i.bad;
    // a lone character in the last quartet is a length error
    err_out   = err_now || (data_i.last && (pos_q == b64d_pkg::PosFirst));
    completes = (pos_q != b64d_pkg::PosFirst);
    emit      = completes || data_i.last;
    good      = completes && !err_out;
  end

  // next state and output register
  always_comb begin
    pos_d       = pos_q;
    left_d      = left_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o) begin
      if (data_i.last) begin
        pos_d  = b64d_pkg::PosFirst;
        left_d = '0;
        err_d  = 1'b0;
      end else begin
        pos_d  = pos_q + 2'd1;
        left_d = left_next;
        err_d  = err_now;
      end
      if (emit) begin
        out_valid_d         = 1'b1;
        out_d.data_byte     = good ? byte_val : 8'd0;
        out_d.byte_valid    = good;
        out_d.end_of_output = data_i.last;
        out_d.error         = err_out;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= b64d_pkg::PosFirst;
      left_q      <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      left_q      <= left_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/base64_unpadded_decoder_top.sv -----
// Unpadded base64 decoder, one character per input transaction.
// Input channel in_valid_i/in_ready_o carries in_data_i: an ASCII character
// and end_of_input marking the last character of a string.
// Output channel out_valid_o/out_ready_i carries out_data_o: data_byte with
// byte_valid, end_of_output and a sticky error flag.
// The second, third and fourth character of each quartet yield one output
// transaction; the first yields one only when it ends the string.
// Throughput: one character per cycle, sustained while out_ready_i is high and QueueDepth is 2 or more.
// A character accepted at the input is classified and written into the queue;
// the core then takes it and registers its result, if any, for out_valid_o.
// The queue between classifier and core holds QueueDepth characters; when the
// receiver stalls, the output register holds and the queue fills, after which
// in_ready_o drops until the receiver takes the waiting transaction.
// Reset clears the queue, the quartet position, leftover bits, error flag and
// output valid; no clearing pass is needed. The quartet position, leftover
// bits and error flag also return to reset after every end-of-input character.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
`timescale 1ns / 1ps

module base64_unpadded_decoder_top #(
  parameter int unsigned QueueDepth = b64d_pkg::QueueDepthDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  b64d_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output b64d_pkg::out_t  out_data_o
);

  logic           push;
  b64d_pkg::cls_t push_data;
  logic           full;
  logic           pop;
  logic           q_valid;
  b64d_pkg::cls_t q_data;

  // character classification
  b64d_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // decoupling queue
  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  // decoder core
  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .data_i      (q_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- rtl/b64d_checker.sv -----
// port-level checks for the unpadded base64 decoder, bound to the top level
// depends on b64d_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64d_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input b64d_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input b64d_pkg::out_t out_data_o
);

  // a waiting input transaction stays offered with the same payload
  `B64D_ASSERT(a_in_hold, clk_i, rst_ni, in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i), "input changed while waiting")

  // a stalled output transaction stays offered
  `B64D_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o, "output dropped while stalled")

  // a decoded byte never goes out together with the error flag
  `B64D_ASSERT(a_byte_no_err, clk_i, rst_ni, out_valid_o && out_data_o.byte_valid |-> !out_data_o.error, "byte marked valid with error set")

  // data_byte is zero when no byte is carried
  `B64D_ASSERT(a_zero_data, clk_i, rst_ni, out_valid_o && !out_data_o.byte_valid |-> out_data_o.data_byte == 8'd0, "nonzero data without valid byte")

  // nothing is offered right out of reset
  `B64D_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> !out_valid_o, "output valid after reset")

endmodule

bind base64_unpadded_decoder_top b64d_checker u_b64d_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
